// ----- src/upe_pkg.sv -----
// Shared types, command codes and character helpers for the URL percent encoder.
// No dependencies; used by every module in src.
package upe_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int STEP_W      = 3;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_PASS,
      CMD_COMMA,
      CMD_BSONLY,
      CMD_BSPASS,
      CMD_QUOTE,
      CMD_HEX,
      CMD_BSHEX,
      CMD_SLASH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   ch;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } front_push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_TWO    = 8'h32;
   localparam logic [7:0] CH_FIVE   = 8'h35;
   localparam logic [7:0] CH_F      = 8'h46;

   function automatic logic is_alnum(input logic [7:0] c);
      logic r;
      r = 1'b0;
      case (c) inside
         [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] r;
      r = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
      return r;
   endfunction

   function automatic logic [STEP_W-1:0] cmd_len(input cmd_kind_type k);
      logic [STEP_W-1:0] r;
      case (k)
         CMD_BSPASS: r = STEP_W'(2);
         CMD_QUOTE,
         CMD_HEX:    r = STEP_W'(3);
         CMD_BSHEX:  r = STEP_W'(4);
         CMD_SLASH:  r = STEP_W'(5);
         default:    r = STEP_W'(1);
      endcase
      return r;
   endfunction

   function automatic logic [7:0] cmd_char(input cmd_type cmd,
                                           input logic [STEP_W-1:0] step);
      logic [7:0] r;
      logic [7:0] hi;
      logic [7:0] lo;
      hi = hex_digit(cmd.ch[7:4]);
      lo = hex_digit(cmd.ch[3:0]);
      r  = cmd.ch;
      case (cmd.kind)
         CMD_PASS:   r = cmd.ch;
         CMD_COMMA:  r = CH_COMMA;
         CMD_BSONLY: r = CH_BSLASH;
         CMD_BSPASS: r = (step == '0) ? CH_BSLASH : cmd.ch;
         CMD_QUOTE:  r = (step == '0) ? CH_PCT : CH_TWO;
         CMD_HEX: begin
            case (step)
               STEP_W'(0): r = CH_PCT;
               STEP_W'(1): r = hi;
               default:    r = lo;
            endcase
         end
         CMD_BSHEX: begin
            case (step)
               STEP_W'(0): r = CH_BSLASH;
               STEP_W'(1): r = CH_PCT;
               STEP_W'(2): r = hi;
               default:    r = lo;
            endcase
         end
         CMD_SLASH: begin
            case (step)
               STEP_W'(0): r = CH_PCT;
               STEP_W'(1): r = CH_TWO;
               STEP_W'(2): r = CH_FIVE;
               STEP_W'(3): r = CH_TWO;
               default:    r = CH_F;
            endcase
         end
         default: r = cmd.ch;
      endcase
      return r;
   endfunction

endpackage

// ----- src/upe_front.sv -----
// Front end: accepts input beats, tracks quote/escape flags, classifies each byte.
// Depends on upe_pkg.
module upe_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_char_in,
   input  logic                    req_end_of_string,
   input  logic                    queue_full,
   output upe_pkg::front_push_type push
);

   logic             inside_quotes_ff, inside_quotes_in;
   logic             escape_pending_ff, escape_pending_in;
   logic             accept;
   upe_pkg::cmd_type cmd;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.ch   = req_char_in;
      cmd.kind = upe_pkg::CMD_HEX;
      if (escape_pending_ff) begin
         case (req_char_in)
            8'h62: cmd.ch = 8'h08;
            8'h6E: cmd.ch = 8'h0A;
            8'h72: cmd.ch = 8'h0D;
            8'h76: cmd.ch = 8'h0B;
            8'h74: cmd.ch = 8'h09;
            default: begin
               cmd.kind = upe_pkg::is_alnum(req_char_in) ? upe_pkg::CMD_BSPASS
                                                         : upe_pkg::CMD_BSHEX;
            end
         endcase
      end else if (req_char_in == upe_pkg::CH_BSLASH) begin
         cmd.kind = req_end_of_string ? upe_pkg::CMD_BSONLY : upe_pkg::CMD_NONE;
      end else if (req_char_in == upe_pkg::CH_QUOTE) begin
         cmd.kind = upe_pkg::CMD_QUOTE;
      end else if (req_char_in == upe_pkg::CH_SLASH && !inside_quotes_ff) begin
         cmd.kind = upe_pkg::CMD_SLASH;
      end else begin
         case (req_char_in) inside
            8'h20, [8'h09:8'h0D]:
               cmd.kind = upe_pkg::CMD_COMMA;
            [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
            8'h2E, 8'h21, 8'h3F, 8'h40, 8'h2A, 8'h7E, 8'h27:
               cmd.kind = upe_pkg::CMD_PASS;
            default:
               cmd.kind = upe_pkg::CMD_HEX;
         endcase
      end
   end

   always_comb begin
      inside_quotes_in  = inside_quotes_ff;
      escape_pending_in = escape_pending_ff;
      if (accept) begin
         if (req_end_of_string) begin
            inside_quotes_in  = 1'b0;
            escape_pending_in = 1'b0;
         end else if (escape_pending_ff) begin
            escape_pending_in = 1'b0;
         end else if (req_char_in == upe_pkg::CH_BSLASH) begin
            escape_pending_in = 1'b1;
         end else if (req_char_in == upe_pkg::CH_QUOTE) begin
            inside_quotes_in = !inside_quotes_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_quotes_ff  <= 1'b0;
         escape_pending_ff <= 1'b0;
      end else begin
         inside_quotes_ff  <= inside_quotes_in;
         escape_pending_ff <= escape_pending_in;
      end
   end

   assign push.push = accept && (cmd.kind != upe_pkg::CMD_NONE);
   assign push.cmd  = cmd;

endmodule

// ----- src/upe_queue.sv -----
// Small command FIFO between front end and expander.
// Depends on upe_pkg.
module upe_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  upe_pkg::front_push_type push,
   output logic                    full,
   input  logic                    pop,
   output upe_pkg::queue_head_type head
);

   upe_pkg::cmd_type             mem_ff [upe_pkg::QUEUE_DEPTH];
   logic [upe_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [upe_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [upe_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                         do_pop;

   assign full       = (count_ff == (upe_pkg::QUEUE_AW+1)'(upe_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         mem_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/upe_back.sv -----
// Back end: expands one queued command into its output characters, one per beat.
// Depends on upe_pkg.
module upe_back (
   input  logic                    clock,
   input  logic                    reset,
   input  upe_pkg::queue_head_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_char_out,
   output logic                    rsp_last_of_run
);

   logic                         busy_ff, busy_in;
   upe_pkg::cmd_type             cmd_ff, cmd_in;
   logic [upe_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                         fire;
   logic                         last_step;
   logic                         take;

   assign last_step = (step_ff == upe_pkg::cmd_len(cmd_ff.kind) - 1'b1);
   assign fire      = busy_ff && rsp_ready;
   assign take      = !busy_ff || (fire && last_step);
   assign pop       = take && head.valid;

   always_comb begin
      busy_in = busy_ff;
      cmd_in  = cmd_ff;
      step_in = step_ff;
      if (take) begin
         busy_in = head.valid;
         cmd_in  = head.cmd;
         step_in = '0;
      end else if (fire) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign rsp_valid       = busy_ff;
   assign rsp_char_out    = upe_pkg::cmd_char(cmd_ff, step_ff);
   assign rsp_last_of_run = last_step;

endmodule

// ----- src/url_percent_encoder_unit.sv -----
// Top level of the URL percent encoder: front end, command queue, expander.
// Depends on upe_pkg, upe_front, upe_queue, upe_back.
//
//   channel   ports                                     direction
//   req       req_valid/ready, req_char_in, req_end_of_string   in
//   rsp       rsp_valid/ready, rsp_char_out, rsp_last_of_run    out
//
// One input beat per cycle while the 4-entry command queue has room.
// The expander sends one character per cycle while rsp_ready is high,
// 1 to 5 per byte by escape length; a held backslash sends none.
// Synchronous active-high reset clears flags, queue pointers and expander.
// rsp stalls back up through the queue to req_ready.
module url_percent_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_char_out,
   output logic       rsp_last_of_run
);

   upe_pkg::front_push_type push;
   upe_pkg::queue_head_type head;
   logic                    queue_full;
   logic                    pop;

   upe_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_in       (req_char_in),
      .req_end_of_string (req_end_of_string),
      .queue_full        (queue_full),
      .push              (push)
   );

   upe_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   upe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_out    (rsp_char_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
